// ----- sv/wbs_pkg.sv -----
// Package for the window block scheduler: operation, status and mark codes,
// register indexes, sequencer states and reset values.
// No dependencies.
package wbs_pkg;

  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_FINISH  = 2'd1,
    OP_RESTART = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_WAIT     = 3'd1,
    ST_DONE     = 3'd2,
    ST_ACCEPTED = 3'd3,
    ST_REJECTED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_GRANT,
    S_FIN_RD,
    S_FIN_WR,
    S_RESP
  } state_t;

  localparam logic [1:0] MARK_UNTOUCHED = 2'd0;
  localparam logic [1:0] MARK_FETCHED   = 2'd1;
  localparam logic [1:0] MARK_FINISHED  = 2'd2;

  localparam logic [1:0] CFG_TOTAL_ROWS     = 2'd0;
  localparam logic [1:0] CFG_ACTIVE_COLUMNS = 2'd1;
  localparam logic [1:0] CFG_WINDOW_ROWS    = 2'd2;

  localparam logic [15:0] RST_TOTAL_ROWS     = 16'd16;
  localparam logic [6:0]  RST_ACTIVE_COLUMNS = 7'd16;
  localparam logic [4:0]  RST_WINDOW_ROWS    = 5'd6;

endpackage

// ----- sv/window_block_scheduler_unit.sv -----
// Window block scheduler: top level. Depends on wbs_pkg and wbs_ram.
//
// The block hands out blocks of a row-by-column grid so that no two running
// jobs share a row or a column. The column marks of every window slot live in
// one RAM row per slot, two bits per column; slot row numbers, valid and held
// bits and the column held bits are flip-flops. A request reads every slot in
// use once, one RAM row per cycle, and keeps the best candidate for the
// caller's own row, for its last column and for any free block; the winner's
// row is then read again and written back with the fetched mark. A finish
// reads, modifies and writes back one row. One item is handled at a time;
// the result register lets the next item in while a result waits to be
// taken. Restart clears the marks at once through a per-row valid bit, so
// there is no clearing pass after reset. Configuration writes take effect
// immediately: window size and column count bound the next scan, but the
// slot row numbers are laid out anew only on the next restart.
module window_block_scheduler_unit #(
  parameter int WINDOW_SLOTS = 16,
  parameter int MAX_COLUMNS  = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  opcode,
  input  logic [15:0] job_row,
  input  logic [7:0]  job_column,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [2:0]  status,
  output logic [15:0] grant_row,
  output logic [5:0]  grant_column,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import wbs_pkg::*;

  localparam int SW  = $clog2(WINDOW_SLOTS);
  localparam int CW  = $clog2(MAX_COLUMNS);
  localparam int WUW = $clog2(WINDOW_SLOTS + 1);
  localparam int NCW = $clog2(MAX_COLUMNS + 1);
  localparam int RW  = 2 * MAX_COLUMNS;
  localparam int RST_FRESH = (WINDOW_SLOTS < 6) ? WINDOW_SLOTS : 6;

  // Configuration registers.
  logic [15:0] total_rows;
  logic [6:0]  active_columns;
  logic [4:0]  window_rows;

  // Window state held in flip-flops.
  logic [15:0]             slot_row_number [WINDOW_SLOTS];
  logic [WINDOW_SLOTS-1:0] slot_valid;
  logic [WINDOW_SLOTS-1:0] slot_held;
  logic [WINDOW_SLOTS-1:0] row_ok;
  logic [MAX_COLUMNS-1:0]  column_held;
  logic [15:0]             next_fresh_row;

  state_t state, state_next;

  // Latched item and scan bookkeeping.
  logic [7:0]     lcol;
  logic [SW-1:0]  own_slot;
  logic           own_found;
  logic [WUW-1:0] scan;
  logic           rd_pend;
  logic [SW-1:0]  rd_slot;
  logic           own_hit, col_hit, any_hit;
  logic [CW-1:0]  own_c, any_c, win_c;
  logic [SW-1:0]  col_slot, any_slot;
  status_t        res_status;
  logic [15:0]    res_row;
  logic [5:0]     res_col;

  // RAM control.
  logic          ram_we, ram_re;
  logic [SW-1:0] ram_waddr, ram_raddr;
  logic [RW-1:0] ram_wdata, ram_q, rd_data;

  wbs_ram #(.WIDTH(RW), .DEPTH(WINDOW_SLOTS)) u_marks (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .q     (ram_q)
  );

  // Saturated window size and column count.
  logic [WUW-1:0] slots_used;
  logic [NCW-1:0] cols_used;

  always_comb begin
    if (window_rows == '0) begin
      slots_used = WUW'(1);
    end else if (32'(window_rows) > WINDOW_SLOTS) begin
      slots_used = WUW'(WINDOW_SLOTS);
    end else begin
      slots_used = WUW'(window_rows);
    end
    if (active_columns == '0) begin
      cols_used = NCW'(1);
    end else if (32'(active_columns) > MAX_COLUMNS) begin
      cols_used = NCW'(MAX_COLUMNS);
    end else begin
      cols_used = NCW'(active_columns);
    end
  end

  logic accept;
  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;

  // First slot in use that holds the item's row, whatever its valid bit.
  logic          find_hit;
  logic [SW-1:0] find_slot;

  always_comb begin
    find_hit  = 1'b0;
    find_slot = '0;
    for (int s = WINDOW_SLOTS - 1; s >= 0; s--) begin
      if (s < 32'(slots_used) && slot_row_number[s] == job_row) begin
        find_hit  = 1'b1;
        find_slot = SW'(s);
      end
    end
  end

  logic in_col_ok;
  assign in_col_ok = 32'(job_column) < 32'(cols_used);

  // A row that has not been written since restart reads as all untouched.
  assign rd_data = row_ok[rd_slot] ? ram_q : '0;

  // First free, untouched column of the row just read.
  logic          row_any;
  logic [CW-1:0] row_first;

  always_comb begin
    row_any   = 1'b0;
    row_first = '0;
    for (int c = MAX_COLUMNS - 1; c >= 0; c--) begin
      if (c < 32'(cols_used) && !column_held[c] &&
          rd_data[2*c +: 2] == MARK_UNTOUCHED) begin
        row_any   = 1'b1;
        row_first = CW'(c);
      end
    end
  end

  logic [CW-1:0] lcol_i;
  logic          col_ok, row_elig, col_cell_free;
  assign lcol_i        = lcol[CW-1:0];
  assign col_ok        = (32'(lcol) < 32'(cols_used)) && !column_held[lcol_i];
  assign row_elig      = slot_valid[rd_slot] && !slot_held[rd_slot];
  assign col_cell_free = rd_data[{lcol_i, 1'b0} +: 2] == MARK_UNTOUCHED;

  logic own_ok;
  assign own_ok = own_found && slot_valid[own_slot] && !slot_held[own_slot];

  // Winner selection in priority order: own row, last column, any block.
  logic          win_any;
  logic [SW-1:0] sel_slot;
  logic [CW-1:0] sel_c;

  always_comb begin
    win_any  = own_hit || col_hit || any_hit;
    sel_slot = any_slot;
    sel_c    = any_c;
    if (own_hit) begin
      sel_slot = own_slot;
      sel_c    = own_c;
    end else if (col_hit) begin
      sel_slot = col_slot;
      sel_c    = lcol_i;
    end
  end

  // Counts of valid and held slots in use, for the wait or done answer.
  logic [WUW-1:0] nvalid, nheld;

  always_comb begin
    nvalid = '0;
    nheld  = '0;
    for (int s = 0; s < WINDOW_SLOTS; s++) begin
      if (s < 32'(slots_used)) begin
        nvalid = nvalid + WUW'(slot_valid[s]);
        nheld  = nheld + WUW'(slot_held[s]);
      end
    end
  end

  // Write-back data for a grant and for a finish.
  logic [RW-1:0] grant_data, fin_data;
  logic          complete, refill;

  always_comb begin
    grant_data = rd_data;
    grant_data[{win_c, 1'b0} +: 2] = MARK_FETCHED;
    fin_data = rd_data;
    fin_data[{lcol_i, 1'b0} +: 2] = MARK_FINISHED;
    complete = 1'b1;
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      if (c < 32'(cols_used) && fin_data[2*c +: 2] != MARK_FINISHED) begin
        complete = 1'b0;
      end
    end
    refill = complete && (next_fresh_row < total_rows);
    if (refill) begin
      for (int c = 0; c < MAX_COLUMNS; c++) begin
        if (c < 32'(cols_used)) begin
          fin_data[2*c +: 2] = MARK_UNTOUCHED;
        end
      end
    end
  end

  logic scan_issue;
  assign scan_issue = scan < slots_used;

  // Next state and RAM control.
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = rd_slot;
    ram_wdata  = grant_data;
    ram_re     = 1'b0;
    ram_raddr  = scan[SW-1:0];
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (opcode)
            OP_REQUEST: state_next = S_SCAN;
            OP_FINISH:  state_next = (find_hit && in_col_ok) ? S_FIN_RD : S_RESP;
            default:    state_next = S_RESP;
          endcase
        end
      end
      S_SCAN: begin
        ram_re = scan_issue;
        if (!scan_issue && !rd_pend) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        ram_raddr = sel_slot;
        if (win_any) begin
          ram_re     = 1'b1;
          state_next = S_GRANT;
        end else begin
          state_next = S_RESP;
        end
      end
      S_GRANT: begin
        ram_we     = 1'b1;
        state_next = S_RESP;
      end
      S_FIN_RD: begin
        ram_re     = 1'b1;
        ram_raddr  = own_slot;
        state_next = S_FIN_WR;
      end
      S_FIN_WR: begin
        ram_we     = 1'b1;
        ram_wdata  = fin_data;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  logic do_restart;
  assign do_restart = accept && opcode == OP_RESTART;

  // Window state, configuration and result registers.
  always_ff @(posedge clk) begin
    if (rst || do_restart) begin
      for (int s = 0; s < WINDOW_SLOTS; s++) begin
        slot_row_number[s] <= 16'(s);
      end
      slot_valid  <= '1;
      slot_held   <= '0;
      row_ok      <= '0;
      column_held <= '0;
      next_fresh_row <= rst ? 16'(RST_FRESH) : 16'(slots_used);
    end
    if (rst) begin
      total_rows     <= RST_TOTAL_ROWS;
      active_columns <= RST_ACTIVE_COLUMNS;
      window_rows    <= RST_WINDOW_ROWS;
      rsp_valid      <= 1'b0;
      rd_pend        <= 1'b0;
      scan           <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_TOTAL_ROWS:     total_rows     <= cfg_data;
          CFG_ACTIVE_COLUMNS: active_columns <= cfg_data[6:0];
          CFG_WINDOW_ROWS:    window_rows    <= cfg_data[4:0];
          default: ;
        endcase
      end

      if (ram_re) begin
        rd_slot <= ram_raddr;
      end
      rd_pend <= (state == S_SCAN) && ram_re;

      // The output register is loaded when it is empty or being emptied.
      if (state == S_RESP && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            lcol       <= job_column;
            own_slot   <= find_slot;
            own_found  <= find_hit;
            scan       <= '0;
            own_hit    <= 1'b0;
            col_hit    <= 1'b0;
            any_hit    <= 1'b0;
            res_row    <= '0;
            res_col    <= '0;
            res_status <= (opcode == OP_RESTART) ? ST_ACCEPTED : ST_REJECTED;
          end
        end
        S_SCAN: begin
          if (scan_issue) begin
            scan <= scan + WUW'(1);
          end
          if (rd_pend) begin
            if (rd_slot == own_slot && own_ok && row_any) begin
              own_hit <= 1'b1;
              own_c   <= row_first;
            end
            if (col_ok && row_elig && col_cell_free && !col_hit) begin
              col_hit  <= 1'b1;
              col_slot <= rd_slot;
            end
            if (row_elig && row_any && !any_hit) begin
              any_hit  <= 1'b1;
              any_slot <= rd_slot;
              any_c    <= row_first;
            end
          end
        end
        S_DECIDE: begin
          win_c <= sel_c;
          if (!win_any) begin
            res_status <= (nheld >= nvalid) ? ST_DONE : ST_WAIT;
          end
        end
        S_GRANT: begin
          slot_held[rd_slot]  <= 1'b1;
          column_held[win_c]  <= 1'b1;
          row_ok[rd_slot]     <= 1'b1;
          res_status <= ST_GRANTED;
          res_row    <= slot_row_number[rd_slot];
          res_col    <= 6'(win_c);
        end
        S_FIN_WR: begin
          slot_held[rd_slot]  <= 1'b0;
          column_held[lcol_i] <= 1'b0;
          row_ok[rd_slot]     <= 1'b1;
          res_status <= ST_ACCEPTED;
          if (complete) begin
            if (refill) begin
              slot_row_number[rd_slot] <= next_fresh_row;
              next_fresh_row <= next_fresh_row + 16'd1;
            end else begin
              slot_valid[rd_slot] <= 1'b0;
            end
          end
        end
        S_RESP: begin
          if (!rsp_valid || !rsp_stall) begin
            status       <= res_status;
            grant_row    <= res_row;
            grant_column <= res_col;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/wbs_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module wbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         q
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q <= mem[raddr];
    end
  end

endmodule
